>>> design/assert_macros.svh
// assertion macros shared by the blend pipeline
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define AOP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define AOP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error("assertion failed");

`endif

>>> design/aop_pkg.sv
// types and constants of the alpha-over blend pipeline
package aop_pkg;

  localparam logic [7:0] FullScale       = 8'd255;
  localparam int unsigned NumChannels    = 3;
  localparam int unsigned QuoBits        = 8;
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned DivStages      = QuoBits / DivBitsPerStage;

  // channel order inside the color vectors: 2 red, 1 green, 0 blue
  typedef logic [NumChannels-1:0][7:0] color_t;

  // one beat traveling through the divider stages
  typedef struct packed {
    logic   valid;
    logic [7:0] ar;
    color_t rem;
    color_t low;
    color_t quo;
  } div_beat_t;

endpackage

>>> design/aop_front.sv
// front stages: bottom weight, result alpha and the weighted channel sums
module aop_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [31:0]       bottom_pixel_i,
  input  logic [31:0]       top_pixel_i,
  output aop_pkg::div_beat_t beat_o
);

  localparam int unsigned NumSums = aop_pkg::NumChannels;

  // stage 1: ab * (255 - at)
  logic               s1_valid_d, s1_valid_q;
  logic [7:0]         s1_at_d, s1_at_q;
  logic [15:0]        s1_prod_d, s1_prod_q;
  aop_pkg::color_t    s1_bot_d, s1_bot_q;
  aop_pkg::color_t    s1_top_d, s1_top_q;

  // stage 2: wb = prod / 255, ar = at + wb
  logic               s2_valid_d, s2_valid_q;
  logic [7:0]         s2_at_d, s2_at_q;
  logic [7:0]         s2_wb_d, s2_wb_q;
  logic [7:0]         s2_ar_d, s2_ar_q;
  aop_pkg::color_t    s2_bot_d, s2_bot_q;
  aop_pkg::color_t    s2_top_d, s2_top_q;
  logic [16:0]        div255_sum;
  logic [8:0]         ar_sum;

  // stage 3: cb * wb + ct * at
  logic               s3_valid_d, s3_valid_q;
  logic [7:0]         s3_ar_d, s3_ar_q;
  aop_pkg::color_t    s3_hi_d, s3_hi_q;
  aop_pkg::color_t    s3_lo_d, s3_lo_q;
  logic [NumSums-1:0][15:0] num;

  assign s1_valid_d = valid_i;
  assign s1_at_d    = top_pixel_i[31:24];
  assign s1_prod_d  = {8'd0, bottom_pixel_i[31:24]} *
                      {8'd0, aop_pkg::FullScale - top_pixel_i[31:24]};
  assign s1_bot_d   = bottom_pixel_i[23:0];
  assign s1_top_d   = top_pixel_i[23:0];

  // exact floor division by 255 for products below 65535
  assign div255_sum = {1'b0, s1_prod_q} + {9'd0, s1_prod_q[15:8]} + 17'd1;
  assign s2_valid_d = s1_valid_q;
  assign s2_at_d    = s1_at_q;
  assign s2_wb_d    = div255_sum[15:8];
  assign ar_sum     = {1'b0, s1_at_q} + {1'b0, div255_sum[15:8]};
  assign s2_ar_d    = ar_sum[7:0];
  assign s2_bot_d   = s1_bot_q;
  assign s2_top_d   = s1_top_q;

  always_comb begin
    for (int ch = 0; ch < NumSums; ch++) begin
      num[ch] = 16'({8'd0, s2_bot_q[ch]} * {8'd0, s2_wb_q}) +
                16'({8'd0, s2_top_q[ch]} * {8'd0, s2_at_q});
      s3_hi_d[ch] = num[ch][15:8];
      s3_lo_d[ch] = num[ch][7:0];
    end
  end
  assign s3_valid_d = s2_valid_q;
  assign s3_ar_d    = s2_ar_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      s3_valid_q <= s3_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_at_q   <= s1_at_d;
    s1_prod_q <= s1_prod_d;
    s1_bot_q  <= s1_bot_d;
    s1_top_q  <= s1_top_d;
    s2_at_q   <= s2_at_d;
    s2_wb_q   <= s2_wb_d;
    s2_ar_q   <= s2_ar_d;
    s2_bot_q  <= s2_bot_d;
    s2_top_q  <= s2_top_d;
    s3_ar_q   <= s3_ar_d;
    s3_hi_q   <= s3_hi_d;
    s3_lo_q   <= s3_lo_d;
  end

  // upper byte of the sum is already below ar, so it seeds the remainder
  always_comb begin
    beat_o       = '0;
    beat_o.valid = s3_valid_q;
    beat_o.ar    = s3_ar_q;
    beat_o.rem   = s3_hi_q;
    beat_o.low   = s3_lo_q;
  end

endmodule

>>> design/aop_div_stage.sv
// one divider stage: a few quotient bits of each channel by the result alpha
module aop_div_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  aop_pkg::div_beat_t beat_i,
  output aop_pkg::div_beat_t beat_o
);

  aop_pkg::div_beat_t beat_d, beat_q;
  logic               valid_d, valid_q;
  logic [8:0]         trial;
  logic               take;

  always_comb begin
    beat_d = beat_i;
    trial  = '0;
    take   = 1'b0;
    for (int ch = 0; ch < aop_pkg::NumChannels; ch++) begin
      for (int s = 0; s < aop_pkg::DivBitsPerStage; s++) begin
        trial = {beat_d.rem[ch], beat_d.low[ch][7]};
        // zero alpha keeps every quotient bit clear
        take  = (trial >= {1'b0, beat_d.ar}) && (beat_d.ar != 8'd0);
        beat_d.rem[ch] = take ? 8'(trial - {1'b0, beat_d.ar}) : trial[7:0];
        beat_d.low[ch] = {beat_d.low[ch][6:0], 1'b0};
        beat_d.quo[ch] = {beat_d.quo[ch][6:0], take};
      end
    end
  end

  assign valid_d = beat_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  always_comb begin
    beat_o       = beat_q;
    beat_o.valid = valid_q;
  end

endmodule

>>> design/alpha_over_pixel_blend.sv
// alpha-over blend of two straight-alpha ARGB8888 pixels, one pixel per cycle
// path: a pixel taken in is registered through the front stages, then the divider stages, to blended_pixel_o
// throughput: one pixel every cycle; busy stays low, the pipeline never stalls
// depth: three front stages (weight, alpha, sums) and four divider stages of two bits
// reset: clears only the valid bits; no result is shown until new pixels enter
module alpha_over_pixel_blend (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] bottom_pixel_i,
  input  logic [31:0] top_pixel_i,
  output logic [31:0] blended_pixel_o,
  output logic        done_o
);

`include "assert_macros.svh"

  aop_pkg::div_beat_t beat [aop_pkg::DivStages+1];

  assign busy = 1'b0;

  aop_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (start),
    .bottom_pixel_i (bottom_pixel_i),
    .top_pixel_i    (top_pixel_i),
    .beat_o         (beat[0])
  );

  for (genvar g = 0; g < aop_pkg::DivStages; g++) begin : g_div
    aop_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .beat_i (beat[g]),
      .beat_o (beat[g+1])
    );
  end

  assign done_o          = beat[aop_pkg::DivStages].valid;
  assign blended_pixel_o = {beat[aop_pkg::DivStages].ar,
                            beat[aop_pkg::DivStages].quo[2],
                            beat[aop_pkg::DivStages].quo[1],
                            beat[aop_pkg::DivStages].quo[0]};

  // zero result alpha clears the whole pixel
  `AOP_ASSERT_IMPL(a_zero_alpha, done_o && (blended_pixel_o[31:24] == 8'd0), (blended_pixel_o == 32'd0))
  // every accepted beat comes out after the fixed latency
  `AOP_ASSERT_IMPL(a_latency, start && !busy, ##7 done_o)
  // an opaque top pixel passes through unchanged
  `AOP_ASSERT_IMPL(a_opaque, start && (top_pixel_i[31:24] == 8'hFF), ##7 (blended_pixel_o == $past(top_pixel_i, 7)))
  // the pipeline never holds off a new beat
  `AOP_ASSERT_NEXT(a_never_busy, 1'b1, !busy)

endmodule

>>> test/tb.sv
// self-checking testbench of the alpha-over pixel blend: random and corner pixels, scoreboard
module tb;

  localparam int unsigned RandomItems = 650;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxGap      = 40;

  class blend_scoreboard;
    logic [31:0] expected_pixels[$];
    int unsigned fails;

    function new();
      fails = 0;
    endfunction

    function logic [31:0] blend_over(logic [31:0] bot, logic [31:0] top);
      int unsigned at, ab, wb, ar, cb, ct, mixed;
      logic [31:0] px;
      at = top[31:24];
      ab = bot[31:24];
      wb = (ab * (int'(aop_pkg::FullScale) - at)) / int'(aop_pkg::FullScale);
      ar = (at + wb) & 8'hFF;
      px = '0;
      px[31:24] = ar[7:0];
      for (int ch = 0; ch < 3; ch++) begin
        cb = (bot >> (8 * ch)) & 8'hFF;
        ct = (top >> (8 * ch)) & 8'hFF;
        mixed = (ar == 0) ? 0 : ((cb * wb + ct * at) / ar);
        px[8*ch +: 8] = mixed[7:0];
      end
      return px;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fails++;
    endtask

    function void note_pixels(logic [31:0] bot, logic [31:0] top);
      expected_pixels.push_back(blend_over(bot, top));
    endfunction

    task check_pixel(logic [31:0] got);
      logic [31:0] want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("unexpected beat %08h", got));
      end else begin
        want = expected_pixels[0];
        expected_pixels.delete(0);
        if (got !== want)
          report($sformatf("blended a/r/g/b got %02h/%02h/%02h/%02h want %02h/%02h/%02h/%02h",
                           got[31:24], got[23:16], got[15:8], got[7:0],
                           want[31:24], want[23:16], want[15:8], want[7:0]));
      end
    endtask

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] bottom_pixel = '0;
  logic [31:0] top_pixel = '0;
  logic [31:0] blended_pixel;
  logic        done;
  int unsigned cycle_cnt = 0;

  blend_scoreboard sb = new();

  alpha_over_pixel_blend dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .bottom_pixel_i  (bottom_pixel),
    .top_pixel_i     (top_pixel),
    .blended_pixel_o (blended_pixel),
    .done_o          (done)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      if ($isunknown(done))
        sb.report("unknown done strobe");
      else if (done)
        sb.check_pixel(blended_pixel);
      if (start && !busy)
        sb.note_pixels(bottom_pixel, top_pixel);
    end
  end

  function logic [7:0] pick_alpha();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'(1 + $urandom_range(1));
      3: return 8'(253 + $urandom_range(1));
      default: return 8'($urandom());
    endcase
  endfunction

  function logic [31:0] pick_pixel();
    return {pick_alpha(), 24'($urandom())};
  endfunction

  task send_pixel(logic [31:0] bot, logic [31:0] top, int unsigned idle_pct);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < MaxGap) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    bottom_pixel <= bot;
    top_pixel    <= top;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned phase_idle[4];
    phase_idle = '{0, 84, 0, 12};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners: extremes, zero result alpha, opaque top
    send_pixel(32'h0000_0000, 32'h0000_0000, 0);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF, 0);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 0);
    send_pixel(32'h00FF_FFFF, 32'h00FF_FFFF, 0);
    send_pixel(32'h0012_3456, 32'h00AB_CDEF, 0);
    send_pixel(32'hFF12_3456, 32'hFFAB_CDEF, 0);
    send_pixel(32'h8012_3456, 32'hFF00_0000, 0);
    send_pixel(32'hAAAA_AAAA, 32'h5555_5555, 0);
    send_pixel(32'h5555_5555, 32'hAAAA_AAAA, 0);
    send_pixel(32'h01FF_FFFF, 32'h0000_0000, 0);
    send_pixel(32'h0000_0000, 32'h01FF_FFFF, 0);
    send_pixel(32'h01FF_FFFF, 32'h0100_0000, 0);
    send_pixel(32'hFFFF_FFFF, 32'hFE00_0000, 0);
    send_pixel(32'hFF00_0000, 32'h01FF_FFFF, 0);
    send_pixel(32'h80FF_00FF, 32'h8000_FF00, 0);
    send_pixel(32'h7FFF_FFFF, 32'h80FF_FFFF, 0);
    send_pixel(32'hFEFF_FFFF, 32'hFEFF_FFFF, 0);
    send_pixel(32'h0180_8080, 32'h0180_8080, 0);
    send_pixel(pick_pixel(), {8'hFF, 24'($urandom())}, 0);

    for (int p = 0; p < 4; p++) begin
      for (int unsigned i = 0; i < RandomItems / 4; i++)
        send_pixel(pick_pixel(), pick_pixel(), phase_idle[p]);
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
